// ===== hdl/i2ctrf_pkg.sv =====
// Shared types and codes for the I2C target register file.
// Holds the input and result item structs, bus event codes and config indexes.
// No dependencies.
`default_nettype none

package i2ctrf_pkg;

  // Default geometry of the register map.
  localparam int NUM_REGS_DEF  = 16;
  localparam int REG_BYTES_DEF = 4;

  // Width of the mask registers; registers at or above this index have no mask bit.
  localparam int MASK_W    = 16;
  localparam int CFG_IDX_W = 4;

  // Bus event codes carried in the func field.
  localparam logic [2:0] FN_WRITE_MATCH = 3'd0;
  localparam logic [2:0] FN_READ_MATCH  = 3'd1;
  localparam logic [2:0] FN_BYTE_RX     = 3'd2;
  localparam logic [2:0] FN_ACK_FAIL    = 3'd3;
  localparam logic [2:0] FN_OTHER_ERR   = 3'd4;
  localparam logic [2:0] FN_LOCAL_LOAD  = 3'd5;

  // Configuration register indexes.
  localparam logic [CFG_IDX_W-1:0] CFG_READONLY = CFG_IDX_W'(0);
  localparam logic [CFG_IDX_W-1:0] CFG_NOTIFY   = CFG_IDX_W'(1);

  typedef struct packed {
    logic [2:0]  func;
    logic [7:0]  data_byte;
    logic [3:0]  load_index;
    logic [31:0] load_value;
  } in_item_t;

  typedef struct packed {
    logic        read_valid;
    logic [31:0] read_word;
    logic        commit;
    logic        stored;
    logic        notify;
    logic [7:0]  commit_addr;
    logic [31:0] commit_value;
  } out_item_t;

endpackage

`default_nettype wire

// ===== hdl/i2ctrf_store.sv =====
// Register store of the I2C target register file: one write port, one read port.
// Read data is registered; per-entry valid bits emulate clear-at-reset.
// No package dependencies.
`default_nettype none

module i2ctrf_store #(
  parameter int NUM_REGS = 16,
  parameter int IDX_W    = 4
) (
  input  wire logic             clk,
  input  wire logic             rst_n,
  input  wire logic             wr_en,
  input  wire logic [IDX_W-1:0] wr_idx,
  input  wire logic [31:0]      wr_data,
  input  wire logic             rd_en,
  input  wire logic [IDX_W-1:0] rd_idx,
  output logic [31:0]           rd_data
);

  logic [31:0]         mem [NUM_REGS];
  logic [NUM_REGS-1:0] vld_r;
  logic [31:0]         rd_data_r;
  logic                rd_vld_r;

  // Storage array; no reset, entries are qualified by their valid bits.
  always_ff @(posedge clk) begin
    if (wr_en) begin
      mem[wr_idx] <= wr_data;
    end
    if (rd_en) begin
      rd_data_r <= mem[rd_idx];
    end
  end

  // Valid bits clear at reset so unwritten entries read as zero.
  always_ff @(posedge clk) begin
    if (!rst_n) begin
      vld_r    <= '0;
      rd_vld_r <= 1'b0;
    end else begin
      if (wr_en) begin
        vld_r[wr_idx] <= 1'b1;
      end
      if (rd_en) begin
        rd_vld_r <= vld_r[rd_idx];
      end
    end
  end

  assign rd_data = rd_vld_r ? rd_data_r : 32'd0;

endmodule

`default_nettype wire

// ===== hdl/i2ctrf_top_placeholder.sv =====
// Bus event controller helpers for the I2C target register file.
// Computes the mask lookup for a register address against a 16-bit mask.
// Depends on i2ctrf_pkg.
`default_nettype none

module i2ctrf_mask_lookup
  import i2ctrf_pkg::*;
(
  input  wire logic [MASK_W-1:0] readonly_mask,
  input  wire logic [MASK_W-1:0] notify_mask,
  input  wire logic [7:0]        addr,
  output logic                   readonly,
  output logic                   notify
);

  logic in_mask;

  // Registers beyond the mask width are writable and never notify.
  assign in_mask  = ({1'b0, addr} < 9'(MASK_W));
  assign readonly = in_mask && readonly_mask[addr[$clog2(MASK_W)-1:0]];
  assign notify   = in_mask && notify_mask[addr[$clog2(MASK_W)-1:0]];

endmodule

`default_nettype wire

// ===== hdl/i2c_target_register_file.sv =====
// Throughput: one item per cycle while the output is not stalled, except a read match,
// which holds the input while the store's registered read port returns the word.
// Reset: synchronous, active low; phase goes idle, masks clear, and the store's valid
// bits clear so every register reads zero with no clearing pass.
// Depends on i2ctrf_pkg, i2ctrf_store and i2ctrf_mask_lookup.
`default_nettype none

module i2c_target_register_file
  import i2ctrf_pkg::*;
#(
  parameter int NUM_REGS  = NUM_REGS_DEF,
  parameter int REG_BYTES = REG_BYTES_DEF
) (
  input  wire logic                 clk,
  input  wire logic                 rst_n,
  input  wire logic                 in_valid,
  output logic                      in_stall,
  input  wire in_item_t             in_item,
  output logic                      out_valid,
  input  wire logic                 out_stall,
  output out_item_t                 out_item,
  input  wire logic                 cfg_valid,
  output logic                      cfg_ready,
  input  wire logic [CFG_IDX_W-1:0] cfg_index,
  input  wire logic [MASK_W-1:0]    cfg_data
);

  localparam int IDX_W = (NUM_REGS > 1) ? $clog2(NUM_REGS) : 1;

  typedef enum logic [1:0] {
    PH_IDLE,
    PH_ADDR,
    PH_DATA
  } phase_t;

  phase_t           phase_r, phase_nxt;
  logic [7:0]       reg_addr_r, reg_addr_nxt;
  logic [2:0]       byte_cnt_r, byte_cnt_nxt;
  logic [31:0]      asm_r, asm_nxt;
  logic             rd_pend_r;
  logic             rd_oor_r;
  logic             out_valid_r, out_valid_nxt;
  out_item_t        out_item_r, out_item_nxt;
  logic [MASK_W-1:0] ro_mask_r, ntf_mask_r;

  logic             in_acc;
  logic             rd_req;
  logic             end_wr;
  logic             addr_in_range;
  logic             addr_ro, addr_ntf;
  logic [7:0]       lidx_ext;
  logic             wr_en;
  logic [IDX_W-1:0] wr_idx;
  logic [31:0]      wr_data;
  logic [31:0]      rd_data;
  logic [31:0]      rd_word;
  out_item_t        res;

  assign in_acc    = in_valid && !in_stall;
  assign in_stall  = rd_pend_r || (out_valid_r && out_stall);
  assign cfg_ready = 1'b1;
  assign rd_req    = in_acc && (in_item.func == FN_READ_MATCH);
  assign out_valid = out_valid_r;
  assign out_item  = out_item_r;

  assign addr_in_range = ({1'b0, reg_addr_r} < 9'(NUM_REGS));
  assign lidx_ext      = {4'b0000, in_item.load_index};
  assign rd_word       = rd_oor_r ? 32'hFFFF_FFFF : rd_data;

  i2ctrf_mask_lookup u_mask (
    .readonly_mask (ro_mask_r),
    .notify_mask   (ntf_mask_r),
    .addr          (reg_addr_r),
    .readonly      (addr_ro),
    .notify        (addr_ntf)
  );

  i2ctrf_store #(
    .NUM_REGS (NUM_REGS),
    .IDX_W    (IDX_W)
  ) u_store (
    .clk     (clk),
    .rst_n   (rst_n),
    .wr_en   (wr_en),
    .wr_idx  (wr_idx),
    .wr_data (wr_data),
    .rd_en   (rd_req),
    .rd_idx  (reg_addr_r[IDX_W-1:0]),
    .rd_data (rd_data)
  );

  // Event decode: phase tracking, byte assembly, end-of-write detection, local loads and read results.
  always_comb begin
    phase_nxt    = phase_r;
    reg_addr_nxt = reg_addr_r;
    byte_cnt_nxt = byte_cnt_r;
    asm_nxt      = asm_r;
    end_wr       = 1'b0;
    wr_en        = 1'b0;
    wr_idx       = reg_addr_r[IDX_W-1:0];
    wr_data      = asm_r;
    res          = '0;
    if (rd_pend_r) begin
      asm_nxt        = rd_word;
      res.read_valid = 1'b1;
      res.read_word  = rd_word;
    end else if (in_acc) begin
      case (in_item.func)
        FN_WRITE_MATCH: begin
          phase_nxt = PH_ADDR;
        end
        FN_BYTE_RX: begin
          if (phase_r == PH_ADDR) begin
            reg_addr_nxt = in_item.data_byte;
            phase_nxt    = PH_DATA;
            byte_cnt_nxt = 3'd0;
            asm_nxt      = 32'd0;
          end else if (phase_r == PH_DATA) begin
            asm_nxt      = asm_r | (32'(in_item.data_byte) << {byte_cnt_r[1:0], 3'b000});
            byte_cnt_nxt = byte_cnt_r + 3'd1;
            if (byte_cnt_nxt >= 3'(REG_BYTES)) begin
              phase_nxt = PH_IDLE;
              end_wr    = 1'b1;
            end
          end
        end
        FN_ACK_FAIL: begin
          if ((phase_r == PH_DATA) && (byte_cnt_r != 3'd0)) begin
            end_wr = 1'b1;
          end
          phase_nxt = PH_IDLE;
        end
        FN_OTHER_ERR: begin
          phase_nxt = PH_IDLE;
        end
        FN_LOCAL_LOAD: begin
          if (lidx_ext < 8'(NUM_REGS)) begin
            wr_en   = 1'b1;
            wr_idx  = lidx_ext[IDX_W-1:0];
            wr_data = in_item.load_value;
          end
        end
        default: begin
        end
      endcase

      // A finished bus write commits when its address is in range.
      if (end_wr && addr_in_range) begin
        wr_en            = !addr_ro;
        wr_data          = asm_nxt;
        res.commit       = 1'b1;
        res.stored       = !addr_ro;
        res.notify       = addr_ntf;
        res.commit_addr  = reg_addr_r;
        res.commit_value = asm_nxt;
      end
    end
  end

  // Result register: a read loads in the cycle after its acceptance, everything else at acceptance.
  always_comb begin
    out_valid_nxt = out_valid_r;
    out_item_nxt  = out_item_r;
    if (rd_pend_r || (in_acc && !rd_req)) begin
      out_valid_nxt = 1'b1;
      out_item_nxt  = res;
    end else if (!out_stall) begin
      out_valid_nxt = 1'b0;
    end
  end

  // State, configuration and registered outputs.
  always_ff @(posedge clk) begin
    out_item_r <= out_item_nxt;
    if (rd_req) begin
      rd_oor_r <= !addr_in_range;
    end
    if (!rst_n) begin
      phase_r     <= PH_IDLE;
      reg_addr_r  <= 8'd0;
      byte_cnt_r  <= 3'd0;
      asm_r       <= 32'd0;
      rd_pend_r   <= 1'b0;
      out_valid_r <= 1'b0;
      ro_mask_r   <= '0;
      ntf_mask_r  <= '0;
    end else begin
      phase_r     <= phase_nxt;
      reg_addr_r  <= reg_addr_nxt;
      byte_cnt_r  <= byte_cnt_nxt;
      asm_r       <= asm_nxt;
      rd_pend_r   <= rd_req;
      out_valid_r <= out_valid_nxt;
      if (cfg_valid && cfg_ready) begin
        if (cfg_index == CFG_READONLY) begin
          ro_mask_r <= cfg_data;
        end else if (cfg_index == CFG_NOTIFY) begin
          ntf_mask_r <= cfg_data;
        end
      end
    end
  end

  // A read wait state never follows directly on another read wait state.
  a_rd_pend_once : assert property (@(posedge clk) disable iff (!rst_n)
    rd_pend_r |=> !rd_pend_r)
    else $error("read wait cycle lasted more than one cycle");

  // The read answer lands in the result register right after the wait cycle.
  a_rd_result : assert property (@(posedge clk) disable iff (!rst_n)
    rd_pend_r |=> (out_valid_r && out_item_r.read_valid))
    else $error("read answer missing after store read");

  // No new item is taken while the store read is outstanding.
  a_rd_blocks_in : assert property (@(posedge clk) disable iff (!rst_n)
    rd_pend_r |-> (in_stall && !wr_en))
    else $error("input accepted or store written during read wait");

  // Store and notify flags only accompany a commit, and a read never commits.
  a_commit_fields : assert property (@(posedge clk) disable iff (!rst_n)
    (out_valid_r && !out_item_r.commit) |->
      (!out_item_r.stored && !out_item_r.notify && (out_item_r.commit_value == 32'd0)))
    else $error("commit fields set without a commit");

endmodule

`default_nettype wire
